// ----- sv/dstwr_pkg.sv -----
// Shared types, codes and constants of the DS-TWR responder.
`default_nettype none

package dstwr_pkg;

  // Stamp width default and fixed field widths
  localparam int STAMP_BITS_DEF = 40;
  localparam int LEN_W          = 7;
  localparam int CODE_W         = 8;
  localparam int DIST_W         = 32;
  localparam int SCALE_W        = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int FRAC_BITS      = 24;

  // Event kinds
  localparam logic [1:0] FUNC_RX      = 2'd0;
  localparam logic [1:0] FUNC_TX_DONE = 2'd1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLL_CODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_ACK_CODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_CODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POLL_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FINAL_LEN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MM_PER_TICK   = 3'd7;

  // Register reset values
  localparam logic [CODE_W-1:0]  RST_POLL_CODE     = 8'd1;
  localparam logic [CODE_W-1:0]  RST_POLL_ACK_CODE = 8'd2;
  localparam logic [CODE_W-1:0]  RST_FINAL_CODE    = 8'd3;
  localparam logic [CODE_W-1:0]  RST_REPORT_CODE   = 8'd4;
  localparam logic [LEN_W-1:0]   RST_MIN_POLL_LEN  = 7'd2;
  localparam logic [LEN_W-1:0]   RST_MIN_FINAL_LEN = 7'd17;
  localparam logic [DIST_W-1:0]  RST_MAX_DIST      = 32'd100000;
  localparam logic [SCALE_W-1:0] RST_MM_PER_TICK   = 32'd78713664;

  localparam logic [DIST_W-1:0]  DIST_INVALID = {DIST_W{1'b1}};

  // Radio actions
  typedef enum logic [1:0] {
    ACT_LISTEN_TMO  = 2'd0,
    ACT_LISTEN_ALL  = 2'd1,
    ACT_SEND_ACK    = 2'd2,
    ACT_SEND_REPORT = 2'd3
  } action_t;

  // Top level sequencing
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } top_state_t;

  // Ranging unit sequencing
  typedef enum logic [3:0] {
    RS_IDLE,
    RS_DEN,
    RS_CHK,
    RS_MUL_A,
    RS_MUL_B,
    RS_MUL_C,
    RS_OVF,
    RS_DIV,
    RS_FIN
  } rng_state_t;

  // Status from the ranging unit
  typedef struct packed {
    logic              done;
    logic              ok;
    logic [DIST_W-1:0] mm;
  } rng_stat_t;

endpackage

`default_nettype wire

// ----- sv/dstwr_in_if.sv -----
// Input event channel of the DS-TWR responder.
`default_nettype none

interface dstwr_in_if
  import dstwr_pkg::*;
#(
  parameter int STAMP_BITS = STAMP_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [LEN_W-1:0]      frame_length;
  logic [CODE_W-1:0]     msg_code;
  logic [CODE_W-1:0]     seq_byte;
  logic [STAMP_BITS-1:0] event_stamp;
  logic [STAMP_BITS-1:0] peer_poll_tx;
  logic [STAMP_BITS-1:0] peer_ack_rx;
  logic [STAMP_BITS-1:0] peer_final_tx;

  modport source (
    output valid, func, frame_length, msg_code, seq_byte,
           event_stamp, peer_poll_tx, peer_ack_rx, peer_final_tx,
    input  ready
  );
  modport sink (
    input  valid, func, frame_length, msg_code, seq_byte,
           event_stamp, peer_poll_tx, peer_ack_rx, peer_final_tx,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/dstwr_out_if.sv -----
// Result channel of the DS-TWR responder.
`default_nettype none

interface dstwr_out_if
  import dstwr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [CODE_W-1:0] frame_code;
  logic [CODE_W-1:0] echo_seq;
  logic [DIST_W-1:0] range_mm;
  logic              distance_ok;

  modport source (
    output valid, action, frame_code, echo_seq, range_mm, distance_ok,
    input  ready
  );
  modport sink (
    input  valid, action, frame_code, echo_seq, range_mm, distance_ok,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/dstwr_cfg_if.sv -----
// Register write channel of the DS-TWR responder.
`default_nettype none

interface dstwr_cfg_if
  import dstwr_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/dstwr_alu.sv -----
// Shared add/subtract unit of the ranging datapath.
`default_nettype none

module dstwr_alu
  import dstwr_pkg::*;
#(
  parameter int W = 2 * STAMP_BITS_DEF + 34
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum
);

  // Two's complement add, or subtract by inverting b with carry in
  assign sum = a + (b ^ {W{sub}}) + {{(W-1){1'b0}}, sub};

endmodule

`default_nettype wire

// ----- sv/dstwr_rng.sv -----
// Ranging unit: shift-add products and restoring divide on one shared adder.
`default_nettype none

module dstwr_rng
  import dstwr_pkg::*;
#(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [STAMP_BITS-1:0] t1,
  input  logic [STAMP_BITS-1:0] t2,
  input  logic [STAMP_BITS-1:0] t3,
  input  logic [STAMP_BITS-1:0] t4,
  input  logic [STAMP_BITS-1:0] t5,
  input  logic [STAMP_BITS-1:0] t6,
  input  logic [SCALE_W-1:0]    scale,
  input  logic [DIST_W-1:0]     max_dist,
  output rng_stat_t             stat
);

  localparam int DW = STAMP_BITS + 1;              // signed difference
  localparam int NW = STAMP_BITS + 3;              // signed denominator
  localparam int W  = 2 * STAMP_BITS + 2 + SCALE_W; // signed scaled product
  localparam int RW = NW - 1 + FRAC_BITS;          // shifted divisor
  localparam int MW = DW;                          // multiplier bits
  localparam int CW = $clog2(MW + 1);

  rng_state_t     state_r, state_nxt;
  logic [DW-1:0]  ra_r, rb_r, da_r, db_r;
  logic [DW-1:0]  ra_nxt, rb_nxt, da_nxt, db_nxt;
  logic [NW-1:0]  den_r, den_nxt;
  logic [RW-1:0]  dd_r, dd_nxt;
  logic [W-1:0]   acc_r, acc_nxt;
  logic [W-1:0]   mcand_r, mcand_nxt;
  logic [MW-1:0]  mplier_r, mplier_nxt;
  logic           sub_r, sub_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [RW-1:0]  rem_r, rem_nxt;
  logic [DIST_W-1:0] quot_r, quot_nxt;
  logic           done_r, done_nxt;
  logic           ok_r, ok_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;

  logic [W-1:0]   alu_a, alu_b, alu_sum;
  logic           alu_sub;
  logic [DW-1:0]  rb_mag, db_mag;
  logic [RW:0]    rem_shift;

  dstwr_alu #(.W(W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  // Magnitudes of the multiplier operands
  assign rb_mag    = rb_r[DW-1] ? (~rb_r + DW'(1)) : rb_r;
  assign db_mag    = db_r[DW-1] ? (~db_r + DW'(1)) : db_r;
  assign rem_shift = {rem_r, quot_r[DIST_W-1]};

  // Steer the shared adder
  always_comb begin
    alu_a   = acc_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      RS_MUL_A, RS_MUL_B, RS_MUL_C: begin
        alu_b   = mplier_r[0] ? mcand_r : '0;
        alu_sub = sub_r;
      end
      RS_OVF: begin
        alu_b   = W'({dd_r, {DIST_W{1'b0}}});
        alu_sub = 1'b1;
      end
      RS_DIV: begin
        alu_a   = W'(rem_shift);
        alu_b   = W'(dd_r);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    da_nxt     = da_r;
    db_nxt     = db_r;
    den_nxt    = den_r;
    dd_nxt     = dd_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    sub_nxt    = sub_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    quot_nxt   = quot_r;
    done_nxt   = 1'b0;
    ok_nxt     = ok_r;
    dist_nxt   = dist_r;
    case (state_r)
      RS_IDLE: begin
        // Take exact signed stamp differences
        if (start) begin
          ra_nxt    = {1'b0, t4} - {1'b0, t1};
          rb_nxt    = {1'b0, t6} - {1'b0, t3};
          da_nxt    = {1'b0, t5} - {1'b0, t4};
          db_nxt    = {1'b0, t3} - {1'b0, t2};
          state_nxt = RS_DEN;
        end
      end
      RS_DEN: begin
        den_nxt   = {{2{ra_r[DW-1]}}, ra_r} + {{2{rb_r[DW-1]}}, rb_r}
                  + {{2{da_r[DW-1]}}, da_r} + {{2{db_r[DW-1]}}, db_r};
        state_nxt = RS_CHK;
      end
      RS_CHK: begin
        // Nonpositive denominator reports zero as valid
        if (den_r[NW-1] || (den_r == '0)) begin
          dist_nxt  = '0;
          ok_nxt    = 1'b1;
          done_nxt  = 1'b1;
          state_nxt = RS_IDLE;
        end else begin
          dd_nxt     = {den_r[NW-2:0], {FRAC_BITS{1'b0}}};
          acc_nxt    = '0;
          mcand_nxt  = W'($signed(ra_r));
          mplier_nxt = rb_mag;
          sub_nxt    = rb_r[DW-1];
          cnt_nxt    = '0;
          state_nxt  = RS_MUL_A;
        end
      end
      RS_MUL_A, RS_MUL_B, RS_MUL_C: begin
        // One shift-add step
        acc_nxt    = alu_sum;
        mcand_nxt  = {mcand_r[W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[MW-1:1]};
        cnt_nxt    = cnt_r + CW'(1);
        if (state_r == RS_MUL_A && cnt_r == CW'(MW - 1)) begin
          mcand_nxt  = W'($signed(da_r));
          mplier_nxt = db_mag;
          sub_nxt    = ~db_r[DW-1];
          cnt_nxt    = '0;
          state_nxt  = RS_MUL_B;
        end else if (state_r == RS_MUL_B && cnt_r == CW'(MW - 1)) begin
          // Numerator moves to the multiplicand, scale becomes multiplier
          acc_nxt    = '0;
          mcand_nxt  = alu_sum;
          mplier_nxt = MW'(scale);
          sub_nxt    = 1'b0;
          cnt_nxt    = '0;
          state_nxt  = RS_MUL_C;
        end else if (state_r == RS_MUL_C && cnt_r == CW'(SCALE_W - 1)) begin
          state_nxt  = RS_OVF;
        end
      end
      RS_OVF: begin
        // Negative product, or quotient of 2^32 or more, is invalid
        if (acc_r[W-1] || !alu_sum[W-1]) begin
          dist_nxt  = DIST_INVALID;
          ok_nxt    = 1'b0;
          done_nxt  = 1'b1;
          state_nxt = RS_IDLE;
        end else begin
          rem_nxt   = acc_r[DIST_W +: RW];
          quot_nxt  = acc_r[DIST_W-1:0];
          cnt_nxt   = '0;
          state_nxt = RS_DIV;
        end
      end
      RS_DIV: begin
        // One restoring divide step
        if (!alu_sum[W-1]) begin
          rem_nxt = alu_sum[RW-1:0];
        end else begin
          rem_nxt = rem_shift[RW-1:0];
        end
        quot_nxt = {quot_r[DIST_W-2:0], ~alu_sum[W-1]};
        cnt_nxt  = cnt_r + CW'(1);
        if (cnt_r == CW'(DIST_W - 1)) begin
          state_nxt = RS_FIN;
        end
      end
      RS_FIN: begin
        if (quot_r == DIST_INVALID || quot_r > max_dist) begin
          dist_nxt = DIST_INVALID;
          ok_nxt   = 1'b0;
        end else begin
          dist_nxt = quot_r;
          ok_nxt   = 1'b1;
        end
        done_nxt  = 1'b1;
        state_nxt = RS_IDLE;
      end
      default: begin
        state_nxt = RS_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    da_r     <= da_nxt;
    db_r     <= db_nxt;
    den_r    <= den_nxt;
    dd_r     <= dd_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    sub_r    <= sub_nxt;
    cnt_r    <= cnt_nxt;
    rem_r    <= rem_nxt;
    quot_r   <= quot_nxt;
    ok_r     <= ok_nxt;
    dist_r   <= dist_nxt;
  end

  assign stat.done = done_r;
  assign stat.ok   = ok_r;
  assign stat.mm   = dist_r;

endmodule

`default_nettype wire

// ----- sv/ds_twr_responder_ranging.sv -----
// Top level of the DS-TWR responder: protocol phase, registers and result buffer.
//
//   channel   direction  handshake       carries
//   in_ch     in         valid/ready     one radio event
//   out_ch    out        valid/ready     one radio action
//   cfg_ch    in         valid/ready     register index and write data
//
// An event other than a valid final is registered as the pending result and moves to the
// output register once that register is free; the next event is taken after that. A
// valid final first waits for the ranging unit, which runs the shift-add multiplies and
// the 32-step divide on one shared adder; a nonpositive denominator ends ranging early,
// as does a negative or too large product.
// Reset is synchronous and returns the phase, stamps and registers to defaults.
// A stalled result holds in the output register while the next event is taken.
`default_nettype none

module ds_twr_responder_ranging
  import dstwr_pkg::*;
#(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  dstwr_in_if.sink      in_ch,
  dstwr_out_if.source   out_ch,
  dstwr_cfg_if.sink     cfg_ch
);

  top_state_t state_r, state_nxt;

  // Configuration registers
  logic [CODE_W-1:0]  poll_code_r, poll_ack_code_r, final_code_r, report_code_r;
  logic [LEN_W-1:0]   min_poll_len_r, min_final_len_r;
  logic [DIST_W-1:0]  max_dist_r;
  logic [SCALE_W-1:0] mm_per_tick_r;

  // Protocol state
  logic                  awaiting_r, awaiting_nxt;
  logic [STAMP_BITS-1:0] poll_rx_r, poll_rx_nxt;
  logic [STAMP_BITS-1:0] ack_tx_r, ack_tx_nxt;

  // Pending result
  action_t           res_action_r, res_action_nxt;
  logic [CODE_W-1:0] res_code_r, res_code_nxt;
  logic [CODE_W-1:0] res_echo_r, res_echo_nxt;
  logic [DIST_W-1:0] res_dist_r, res_dist_nxt;
  logic              res_ok_r, res_ok_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  action_t           out_action_r, out_action_nxt;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic [CODE_W-1:0] out_echo_r, out_echo_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic              out_ok_r, out_ok_nxt;

  logic       rng_start;
  rng_stat_t  rng_stat;
  logic       poll_ok, final_ok;

  dstwr_rng #(.STAMP_BITS(STAMP_BITS)) u_rng (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rng_start),
    .t1       (in_ch.peer_poll_tx),
    .t2       (poll_rx_r),
    .t3       (ack_tx_r),
    .t4       (in_ch.peer_ack_rx),
    .t5       (in_ch.peer_final_tx),
    .t6       (in_ch.event_stamp),
    .scale    (mm_per_tick_r),
    .max_dist (max_dist_r),
    .stat     (rng_stat)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Frame checks
  assign poll_ok  = (in_ch.frame_length >= min_poll_len_r) && (in_ch.msg_code == poll_code_r);
  assign final_ok = (in_ch.frame_length >= min_final_len_r) &&
                    (in_ch.msg_code == final_code_r);

  // Event handling and result hand-off
  always_comb begin
    state_nxt      = state_r;
    awaiting_nxt   = awaiting_r;
    poll_rx_nxt    = poll_rx_r;
    ack_tx_nxt     = ack_tx_r;
    res_action_nxt = res_action_r;
    res_code_nxt   = res_code_r;
    res_echo_nxt   = res_echo_r;
    res_dist_nxt   = res_dist_r;
    res_ok_nxt     = res_ok_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_action_nxt = out_action_r;
    out_code_nxt   = out_code_r;
    out_echo_nxt   = out_echo_r;
    out_dist_nxt   = out_dist_r;
    out_ok_nxt     = out_ok_r;
    rng_start      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          res_action_nxt = ACT_LISTEN_TMO;
          res_code_nxt   = '0;
          res_echo_nxt   = '0;
          res_dist_nxt   = '0;
          res_ok_nxt     = 1'b0;
          state_nxt      = ST_EMIT;
          case (in_ch.func)
            FUNC_RX: begin
              if (!awaiting_r) begin
                // Answer a valid poll with an ack
                if (poll_ok) begin
                  poll_rx_nxt    = in_ch.event_stamp;
                  awaiting_nxt   = 1'b1;
                  res_action_nxt = ACT_SEND_ACK;
                  res_code_nxt   = poll_ack_code_r;
                  res_echo_nxt   = in_ch.seq_byte;
                end
              end else begin
                // Any frame ends the exchange; a valid final starts ranging
                awaiting_nxt = 1'b0;
                if (final_ok) begin
                  rng_start      = 1'b1;
                  res_action_nxt = ACT_SEND_REPORT;
                  res_code_nxt   = report_code_r;
                  res_echo_nxt   = in_ch.seq_byte;
                  state_nxt      = ST_CALC;
                end
              end
            end
            FUNC_TX_DONE: begin
              if (awaiting_r) begin
                ack_tx_nxt = in_ch.event_stamp;
              end
            end
            default: begin
              awaiting_nxt   = 1'b0;
              res_action_nxt = ACT_LISTEN_ALL;
            end
          endcase
        end
      end
      ST_CALC: begin
        if (rng_stat.done) begin
          res_dist_nxt = rng_stat.mm;
          res_ok_nxt   = rng_stat.ok;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Move the result once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = res_action_r;
          out_code_nxt   = res_code_r;
          out_echo_nxt   = res_echo_r;
          out_dist_nxt   = res_dist_r;
          out_ok_nxt     = res_ok_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and protocol state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      awaiting_r  <= 1'b0;
      poll_rx_r   <= '0;
      ack_tx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      awaiting_r  <= awaiting_nxt;
      poll_rx_r   <= poll_rx_nxt;
      ack_tx_r    <= ack_tx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_action_r <= res_action_nxt;
    res_code_r   <= res_code_nxt;
    res_echo_r   <= res_echo_nxt;
    res_dist_r   <= res_dist_nxt;
    res_ok_r     <= res_ok_nxt;
    out_action_r <= out_action_nxt;
    out_code_r   <= out_code_nxt;
    out_echo_r   <= out_echo_nxt;
    out_dist_r   <= out_dist_nxt;
    out_ok_r     <= out_ok_nxt;
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_code_r     <= RST_POLL_CODE;
      poll_ack_code_r <= RST_POLL_ACK_CODE;
      final_code_r    <= RST_FINAL_CODE;
      report_code_r   <= RST_REPORT_CODE;
      min_poll_len_r  <= RST_MIN_POLL_LEN;
      min_final_len_r <= RST_MIN_FINAL_LEN;
      max_dist_r      <= RST_MAX_DIST;
      mm_per_tick_r   <= RST_MM_PER_TICK;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_POLL_CODE:     poll_code_r     <= cfg_ch.data[CODE_W-1:0];
        REG_POLL_ACK_CODE: poll_ack_code_r <= cfg_ch.data[CODE_W-1:0];
        REG_FINAL_CODE:    final_code_r    <= cfg_ch.data[CODE_W-1:0];
        REG_REPORT_CODE:   report_code_r   <= cfg_ch.data[CODE_W-1:0];
        REG_MIN_POLL_LEN:  min_poll_len_r  <= cfg_ch.data[LEN_W-1:0];
        REG_MIN_FINAL_LEN: min_final_len_r <= cfg_ch.data[LEN_W-1:0];
        REG_MAX_DIST:      max_dist_r      <= cfg_ch.data[DIST_W-1:0];
        REG_MM_PER_TICK:   mm_per_tick_r   <= cfg_ch.data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.action      = out_action_r;
  assign out_ch.frame_code  = out_code_r;
  assign out_ch.echo_seq    = out_echo_r;
  assign out_ch.range_mm    = out_dist_r;
  assign out_ch.distance_ok = out_ok_r;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the DS-TWR responder: directed, register and random ranging traffic.
`default_nettype none

module tb;
  import dstwr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB          = STAMP_BITS_DEF;
  localparam int LEN_MAX     = (1 << LEN_W) - 1;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 200;

  // Event kinds the package leaves unnamed
  localparam logic [1:0] FUNC_FAULT = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef logic [SB-1:0] stamp_t;
  typedef logic signed [255:0] exact_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] seq;
    stamp_t            stamp;
    stamp_t            t1;
    stamp_t            t4;
    stamp_t            t5;
  } radio_event_t;

  typedef struct packed {
    action_t           action;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] seq;
    logic [DIST_W-1:0] mm;
    logic              ok;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  dstwr_in_if #(.STAMP_BITS(SB)) in_ch ();
  dstwr_out_if                   out_ch ();
  dstwr_cfg_if                   cfg_ch ();

  ds_twr_responder_ranging #(.STAMP_BITS(SB)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  // Responder copy: registers, phase and stamps
  logic [CODE_W-1:0]  reg_poll_code, reg_poll_ack_code, reg_final_code, reg_report_code;
  logic [LEN_W-1:0]   reg_min_poll_len, reg_min_final_len;
  logic [DIST_W-1:0]  reg_max_dist;
  logic [SCALE_W-1:0] reg_mm_per_tick;
  logic               rsp_awaiting_final;
  stamp_t             rsp_poll_rx, rsp_ack_tx;

  reply_t awaited_replies[$];

  bit idle_en;
  bit in_gappy;
  int in_mode_left;
  int n_sent, n_checked, n_errors, n_settings;
  int n_acks, n_reports, n_valid, n_invalid, n_faults;

  function automatic exact_t widen(input stamp_t s);
    exact_t w;
    w = '0;
    w[SB-1:0] = s;
    return w;
  endfunction

  function automatic stamp_t rand_stamp();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[SB-1:0];
  endfunction

  function automatic radio_event_t radio_event(input logic [1:0] f, input logic [LEN_W-1:0] l,
                                               input logic [CODE_W-1:0] c, s,
                                               input stamp_t st, t1, t4, t5);
    radio_event_t ev;
    ev.func  = f;
    ev.len   = l;
    ev.code  = c;
    ev.seq   = s;
    ev.stamp = st;
    ev.t1    = t1;
    ev.t4    = t4;
    ev.t5    = t5;
    return ev;
  endfunction

  // Distance from the six stamps, exact integers, floor of the scaled quotient
  function automatic void tof_distance(input stamp_t t1, t4, t5, t6,
                                       output logic [DIST_W-1:0] mm, output logic ok);
    exact_t ra, rb, da, db, den, num, scale, prod, q;
    ra  = widen(t4) - widen(t1);
    rb  = widen(t6) - widen(rsp_ack_tx);
    da  = widen(t5) - widen(t4);
    db  = widen(rsp_ack_tx) - widen(rsp_poll_rx);
    den = ra + rb + da + db;
    mm  = '0;
    ok  = 1'b1;
    if (den <= 0) return;
    num   = ra * rb - da * db;
    scale = '0;
    scale[SCALE_W-1:0] = reg_mm_per_tick;
    prod = num * scale;
    if (prod < 0) begin
      mm = DIST_INVALID;
      ok = 1'b0;
      return;
    end
    q = prod / (den <<< FRAC_BITS);
    if (q[255:DIST_W] != '0 || q[DIST_W-1:0] == DIST_INVALID ||
        q[DIST_W-1:0] > reg_max_dist) begin
      mm = DIST_INVALID;
      ok = 1'b0;
    end else begin
      mm = q[DIST_W-1:0];
    end
  endfunction

  // Advance the responder copy by one event and return the radio action it causes
  function automatic reply_t respond(input radio_event_t ev);
    reply_t r;
    logic [DIST_W-1:0] d;
    logic k;
    r = '0;
    r.action = ACT_LISTEN_TMO;
    case (ev.func)
      FUNC_RX: begin
        if (!rsp_awaiting_final) begin
          if (ev.len >= reg_min_poll_len && ev.code == reg_poll_code) begin
            rsp_poll_rx        = ev.stamp;
            rsp_awaiting_final = 1'b1;
            r.action = ACT_SEND_ACK;
            r.code   = reg_poll_ack_code;
            r.seq    = ev.seq;
          end
        end else begin
          rsp_awaiting_final = 1'b0;
          if (ev.len >= reg_min_final_len && ev.code == reg_final_code) begin
            tof_distance(ev.t1, ev.t4, ev.t5, ev.stamp, d, k);
            r.action = ACT_SEND_REPORT;
            r.code   = reg_report_code;
            r.seq    = ev.seq;
            r.mm     = d;
            r.ok     = k;
          end
        end
      end
      FUNC_TX_DONE: begin
        if (rsp_awaiting_final) rsp_ack_tx = ev.stamp;
      end
      default: begin
        rsp_awaiting_final = 1'b0;
        r.action = ACT_LISTEN_ALL;
      end
    endcase
    return r;
  endfunction

  function automatic void log_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR: %s", msg);
  endfunction

  // Drive one event and hold it until the transfer; valid stays high for the next one
  task automatic send_event(input radio_event_t ev);
    reply_t r;
    if (in_mode_left == 0) begin
      in_gappy     = $urandom_range(0, 1);
      in_mode_left = $urandom_range(10, 60);
    end else begin
      in_mode_left--;
    end
    if (idle_en && in_gappy && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= ev.func;
    in_ch.frame_length  <= ev.len;
    in_ch.msg_code      <= ev.code;
    in_ch.seq_byte      <= ev.seq;
    in_ch.event_stamp   <= ev.stamp;
    in_ch.peer_poll_tx  <= ev.t1;
    in_ch.peer_ack_rx   <= ev.t4;
    in_ch.peer_final_tx <= ev.t5;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = respond(ev);
    awaited_replies.push_back(r);
    n_sent++;
    case (r.action)
      ACT_SEND_ACK: n_acks++;
      ACT_SEND_REPORT: begin
        n_reports++;
        if (r.ok) n_valid++;
        else n_invalid++;
      end
      ACT_LISTEN_ALL: n_faults++;
      default: ;
    endcase
  endtask

  // Drop valid and hold until every expected action has come back
  task automatic wait_replies_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_POLL_CODE:     reg_poll_code     = data[CODE_W-1:0];
      REG_POLL_ACK_CODE: reg_poll_ack_code = data[CODE_W-1:0];
      REG_FINAL_CODE:    reg_final_code    = data[CODE_W-1:0];
      REG_REPORT_CODE:   reg_report_code   = data[CODE_W-1:0];
      REG_MIN_POLL_LEN:  reg_min_poll_len  = data[LEN_W-1:0];
      REG_MIN_FINAL_LEN: reg_min_final_len = data[LEN_W-1:0];
      REG_MAX_DIST:      reg_max_dist      = data[DIST_W-1:0];
      REG_MM_PER_TICK:   reg_mm_per_tick   = data[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // Write all registers while idle; unused upper data bits carry junk
  task automatic program_registers(input logic [CODE_W-1:0] pc, ac, fc, rc,
                                   input logic [LEN_W-1:0] mp, mf,
                                   input logic [DIST_W-1:0] md, input logic [SCALE_W-1:0] sc);
    logic [31:0] junk;
    wait_replies_drained();
    junk = $urandom();
    write_reg(REG_POLL_CODE,     {junk[31:CODE_W], pc});
    write_reg(REG_POLL_ACK_CODE, {junk[30:CODE_W], 1'b1, ac});
    write_reg(REG_FINAL_CODE,    {~junk[31:CODE_W], fc});
    write_reg(REG_REPORT_CODE,   {junk[31:CODE_W], rc});
    write_reg(REG_MIN_POLL_LEN,  {junk[31:LEN_W], mp});
    write_reg(REG_MIN_FINAL_LEN, {~junk[31:LEN_W], mf});
    write_reg(REG_MAX_DIST,      md);
    write_reg(REG_MM_PER_TICK,   sc);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // One poll / ack / final session with plausible stamps, now and then broken
  task automatic run_exchange();
    stamp_t bi, br, t1, t2, t3, t4, t5, t6;
    int unsigned tof, da, db, flaw;
    int jitter;
    logic [LEN_W-1:0] len;
    logic [CODE_W-1:0] code;
    if (rsp_awaiting_final)
      send_event(radio_event(FUNC_FAULT, $urandom(), $urandom(), $urandom(), rand_stamp(),
                             rand_stamp(), rand_stamp(), rand_stamp()));
    tof    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2000000) : $urandom_range(0, 24000);
    da     = $urandom_range(100, 1 << 22);
    db     = $urandom_range(100, 1 << 22);
    jitter = $urandom_range(0, 40);
    jitter = jitter - 20;
    bi = ($urandom_range(0, 15) == 0) ? ('1 - $urandom_range(0, 1 << 20)) : rand_stamp();
    br = ($urandom_range(0, 15) == 0) ? ('1 - $urandom_range(0, 1 << 20)) : rand_stamp();
    t1 = bi;
    t4 = bi + db + 2 * tof;
    t5 = t4 + da;
    t2 = br;
    t3 = br + db;
    t6 = t3 + da + 2 * tof + stamp_t'(jitter);
    if ($urandom_range(0, 9) == 0) begin
      t1 = rand_stamp();
      t4 = rand_stamp();
      t5 = rand_stamp();
      t6 = rand_stamp();
    end
    flaw = $urandom_range(0, 11);

    // Poll
    len  = $urandom_range(reg_min_poll_len, LEN_MAX);
    code = reg_poll_code;
    if (flaw == 0) begin
      if (reg_min_poll_len != 0 && $urandom_range(0, 1))
        len = $urandom_range(0, reg_min_poll_len - 1);
      else code = code ^ CODE_W'($urandom_range(1, 255));
    end
    send_event(radio_event(FUNC_RX, len, code, $urandom(), t2, rand_stamp(), rand_stamp(),
                           rand_stamp()));

    // Ack transmit done
    if (flaw != 1)
      send_event(radio_event(FUNC_TX_DONE, $urandom(), $urandom(), $urandom(), t3, rand_stamp(),
                             rand_stamp(), rand_stamp()));
    if (flaw == 3)
      send_event(radio_event(FUNC_FAULT | 2'($urandom_range(0, 1)), $urandom(), $urandom(),
                             $urandom(), rand_stamp(), rand_stamp(), rand_stamp(), rand_stamp()));

    // Final
    len  = $urandom_range(reg_min_final_len, LEN_MAX);
    code = reg_final_code;
    if (flaw == 2) begin
      if (reg_min_final_len != 0 && $urandom_range(0, 1))
        len = $urandom_range(0, reg_min_final_len - 1);
      else code = code ^ CODE_W'($urandom_range(1, 255));
    end
    send_event(radio_event(FUNC_RX, len, code, $urandom(), t6, t1, t4, t5));
    if (flaw == 4)
      send_event(radio_event(FUNC_TX_DONE, $urandom(), $urandom(), $urandom(), rand_stamp(),
                             rand_stamp(), rand_stamp(), rand_stamp()));
  endtask

  // Mostly whole sessions, the rest loose events; sometimes hold until the pipe is empty
  task automatic run_session(input int n);
    int stop_at;
    int pick;
    logic [CODE_W-1:0] code;
    stop_at = n_sent + n;
    while (n_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        wait_replies_drained();
      end else if (pick < 75) begin
        run_exchange();
      end else begin
        case ($urandom_range(0, 2))
          0:       code = reg_poll_code;
          1:       code = reg_final_code;
          default: code = $urandom();
        endcase
        send_event(radio_event($urandom_range(0, 3), $urandom(), code, $urandom(), rand_stamp(),
                               rand_stamp(), rand_stamp(), rand_stamp()));
      end
    end
  endtask

  // Reset register values: each protocol branch and each distance special case
  task automatic test_protocol_cases();
    send_event(radio_event(FUNC_TX_DONE, 0, 0, 0, '1, 0, 0, 0));
    send_event(radio_event(FUNC_RX, 1, RST_POLL_CODE, 8'h07, 0, 0, 0, 0));
    send_event(radio_event(FUNC_RX, LEN_MAX, 8'hFF, 8'h80, 0, 0, 0, 0));
    // clean ranging session, 200 ticks of flight
    send_event(radio_event(FUNC_RX, RST_MIN_POLL_LEN, RST_POLL_CODE, 8'h00, 0, 0, 0, 0));
    send_event(radio_event(FUNC_TX_DONE, 0, 0, 0, 1000, 0, 0, 0));
    send_event(radio_event(FUNC_RX, RST_MIN_FINAL_LEN, RST_FINAL_CODE, 8'hFF, 4400,
                           5000, 6400, 9400));
    send_event(radio_event(FUNC_SPARE, 7'h55, 8'hAA, 8'h55, 40'hAA_AAAA_AAAA, 0, 0, 0));
    // short final while waiting
    send_event(radio_event(FUNC_RX, 5, RST_POLL_CODE, 8'h01, 100, 0, 0, 0));
    send_event(radio_event(FUNC_RX, RST_MIN_FINAL_LEN - 1, RST_FINAL_CODE, 8'h02, 200, 0, 0, 0));
    // wrong final type while waiting
    send_event(radio_event(FUNC_RX, 5, RST_POLL_CODE, 8'h03, 100, 0, 0, 0));
    send_event(radio_event(FUNC_RX, RST_MIN_FINAL_LEN, RST_REPORT_CODE, 8'h04, 200, 0, 0, 0));
    // timeout while waiting
    send_event(radio_event(FUNC_RX, 5, RST_POLL_CODE, 8'h05, 100, 0, 0, 0));
    send_event(radio_event(FUNC_FAULT, 0, 0, 0, 0, 0, 0, 0));
    // zero denominator
    send_event(radio_event(FUNC_RX, 5, RST_POLL_CODE, 8'h06, 0, 0, 0, 0));
    send_event(radio_event(FUNC_TX_DONE, 0, 0, 0, 0, 0, 0, 0));
    send_event(radio_event(FUNC_RX, 20, RST_FINAL_CODE, 8'h07, 0, 0, 0, 0));
    // negative numerator
    send_event(radio_event(FUNC_RX, 5, RST_POLL_CODE, 8'h08, 0, 0, 0, 0));
    send_event(radio_event(FUNC_TX_DONE, 0, 0, 0, 1000, 0, 0, 0));
    send_event(radio_event(FUNC_RX, 20, RST_FINAL_CODE, 8'h09, 1000, 0, 0, 10));
    // beyond the distance limit, 30000 ticks of flight
    send_event(radio_event(FUNC_RX, 5, RST_POLL_CODE, 8'h0A, 0, 0, 0, 0));
    send_event(radio_event(FUNC_TX_DONE, 0, 0, 0, 100, 0, 0, 0));
    send_event(radio_event(FUNC_RX, 20, RST_FINAL_CODE, 8'h0B, 60200, 0, 60100, 60200));
    // all-ones fields
    send_event(radio_event(FUNC_RX, LEN_MAX, RST_POLL_CODE, 8'hFF, '1, '1, '1, '1));
    send_event(radio_event(FUNC_TX_DONE, LEN_MAX, 8'hFF, 8'hFF, '1, '1, '1, '1));
    send_event(radio_event(FUNC_RX, LEN_MAX, RST_FINAL_CODE, 8'hFF, '1, '1, '1, '1));
  endtask

  // Register extremes: limits, zero scale, full scale, zero distance bound
  task automatic test_register_extremes();
    program_registers(8'h00, 8'hFF, 8'hFF, 8'h00, 7'(LEN_MAX), 0, 0, '1);
    send_event(radio_event(FUNC_RX, LEN_MAX - 1, 8'h00, 8'h11, rand_stamp(), 0, 0, 0));
    send_event(radio_event(FUNC_RX, LEN_MAX, 8'h00, 8'h12, 0, 0, 0, 0));
    send_event(radio_event(FUNC_TX_DONE, 0, 0, 0, 1000, 0, 0, 0));
    send_event(radio_event(FUNC_RX, 0, 8'hFF, 8'h13, 4400, 5000, 6400, 9400));
    repeat (4) run_exchange();

    program_registers(8'hA5, 8'h5A, 8'hC3, 8'h3C, 0, 7'(LEN_MAX), 32'hFFFF_FFFE, 0);
    send_event(radio_event(FUNC_RX, 0, 8'hA5, 8'h21, 0, 0, 0, 0));
    send_event(radio_event(FUNC_TX_DONE, 0, 0, 0, 1000, 0, 0, 0));
    send_event(radio_event(FUNC_RX, LEN_MAX - 1, 8'hC3, 8'h22, 4400, 5000, 6400, 9400));
    send_event(radio_event(FUNC_RX, 0, 8'hA5, 8'h23, 0, 0, 0, 0));
    send_event(radio_event(FUNC_RX, LEN_MAX, 8'hC3, 8'h24, 4400, 5000, 6400, 9400));
    repeat (4) run_exchange();
  endtask

  // Random sessions over several register settings; the last one runs without idling
  task automatic test_random_traffic();
    logic [CODE_W-1:0] code;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: program_registers(RST_POLL_CODE, RST_POLL_ACK_CODE, RST_FINAL_CODE, RST_REPORT_CODE,
                             RST_MIN_POLL_LEN, RST_MIN_FINAL_LEN, RST_MAX_DIST, RST_MM_PER_TICK);
        1: program_registers($urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom_range(0, 20), $urandom_range(0, 40), $urandom(),
                             $urandom_range(60000000, 100000000));
        2: begin
          code = $urandom();
          program_registers(code, $urandom(), code, $urandom(), 0, 0, 32'hFFFF_FFFE, $urandom());
        end
        default: begin
          program_registers(RST_POLL_CODE, RST_POLL_ACK_CODE, RST_FINAL_CODE, RST_REPORT_CODE,
                            RST_MIN_POLL_LEN, RST_MIN_FINAL_LEN, 32'd200000, RST_MM_PER_TICK);
          idle_en = 1'b0;
        end
      endcase
      run_session(390);
    end
  endtask

  // Compare each transferred action with the oldest expectation
  always @(posedge clk) begin : check_replies
    reply_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.action = action_t'(out_ch.action);
      got.code   = out_ch.frame_code;
      got.seq    = out_ch.echo_seq;
      got.mm     = out_ch.range_mm;
      got.ok     = out_ch.distance_ok;
      if (awaited_replies.size() == 0) begin
        log_error($sformatf("unexpected action %0d code %0h seq %0h dist %0h ok %0b",
                            got.action, got.code, got.seq, got.mm, got.ok));
      end else begin
        want = awaited_replies.pop_front();
        if (got.action !== want.action || got.code !== want.code || got.seq !== want.seq ||
            got.mm !== want.mm || got.ok !== want.ok)
          log_error($sformatf({"reply %0d: expected action %0d code %0h seq %0h dist %0h ok %0b,",
                               " got action %0d code %0h seq %0h dist %0h ok %0b"},
                              n_checked, want.action, want.code, want.seq, want.mm, want.ok,
                              got.action, got.code, got.seq, got.mm, got.ok));
      end
      n_checked++;
    end
  end

  // Result side: ready drops in bursts during busy stretches
  initial begin : result_sink
    int stall_left, mode_left;
    bit gappy;
    stall_left = 0;
    mode_left  = 0;
    gappy      = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        gappy     = $urandom_range(0, 1);
        mode_left = $urandom_range(30, 150);
      end else begin
        mode_left--;
      end
      if (stall_left == 0 && idle_en && gappy && $urandom_range(0, 3) == 0)
        stall_left = $urandom_range(1, 6);
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // End the run when no channel has moved for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : main
    // Hold every input at a known value through reset
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.func          <= FUNC_RX;
    in_ch.frame_length  <= '0;
    in_ch.msg_code      <= '0;
    in_ch.seq_byte      <= '0;
    in_ch.event_stamp   <= '0;
    in_ch.peer_poll_tx  <= '0;
    in_ch.peer_ack_rx   <= '0;
    in_ch.peer_final_tx <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_POLL_CODE;
    cfg_ch.data         <= '0;
    reg_poll_code       = RST_POLL_CODE;
    reg_poll_ack_code   = RST_POLL_ACK_CODE;
    reg_final_code      = RST_FINAL_CODE;
    reg_report_code     = RST_REPORT_CODE;
    reg_min_poll_len    = RST_MIN_POLL_LEN;
    reg_min_final_len   = RST_MIN_FINAL_LEN;
    reg_max_dist        = RST_MAX_DIST;
    reg_mm_per_tick     = RST_MM_PER_TICK;
    rsp_awaiting_final  = 1'b0;
    rsp_poll_rx         = '0;
    rsp_ack_tx          = '0;
    idle_en             = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_protocol_cases();
    test_register_extremes();
    test_random_traffic();

    // Let the last actions come back, then watch for strays
    wait_replies_drained();
    repeat (SETTLE) @(posedge clk);
    if (awaited_replies.size() != 0)
      log_error($sformatf("%0d actions never arrived", awaited_replies.size()));

    $display("Ran %0d radio events over %0d register settings, %0d actions checked.",
             n_sent, n_settings, n_checked);
    $display("Acks %0d, reports %0d (%0d in range, %0d flagged), fault resets %0d, errors %0d.",
             n_acks, n_reports, n_valid, n_invalid, n_faults, n_errors);
    if (n_errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ----- ds_twr_responder_ranging.f -----
sv/dstwr_pkg.sv
sv/dstwr_in_if.sv
sv/dstwr_out_if.sv
sv/dstwr_cfg_if.sv
sv/dstwr_alu.sv
sv/dstwr_rng.sv
sv/ds_twr_responder_ranging.sv
dv/tb.sv
